FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is low.
`define TBA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property, checked during reset as well.
`define TBA_ASSERT_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/tba_pkg.sv
package tba_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_NUM_COLUMNS = 2'd0;
    localparam logic [1:0] REG_BIN_PERIOD  = 2'd1;
    localparam logic [1:0] REG_FILL_VALUE  = 2'd2;

    localparam logic [4:0]  NUM_COLUMNS_RST = 5'd2;
    localparam logic [30:0] BIN_PERIOD_RST  = 31'd65536;
    localparam logic [31:0] FILL_VALUE_RST  = 32'd0;

    localparam logic [31:0] INT32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] INT32_MIN = 32'h8000_0000;
    localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [31:0] UINT32_MAX = 32'hFFFF_FFFF;
    localparam logic [31:0] BIN_NONE   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] sample;
    } t_in_word;

    typedef struct packed {
        logic [3:0]         out_column;
        logic signed [31:0] out_value;
        logic               last;
    } t_out_word;

    typedef struct packed {
        logic [63:0] sum;
        logic [31:0] cnt;
    } t_col_entry;

endpackage

FILE: sv/time_bin_averager_core.sv
// channel | dir | handshake                    | word
// config  | in  | psel, penable, pwrite/pready | paddr, pwdata, prdata
// input   | in  | i_in_valid / o_in_stall      | i_in_word  (kind, sample)
// output  | out | o_out_valid / i_out_stall    | o_out_word (out_column, out_value, last)
// Element word: an S_ACC step when it updates a column sum (read-modify-write of the column store).
// Time tag: 32 divide steps of the shared divide/multiply unit; a bin change adds a dump if the bin had records.
// Bin dump: the centre time (31 shift-add steps) as column 0, then per column a store read, or
// a read and 64 restoring divide steps when the column has data, and a wait on any output stall.
// Reset: synchronous; column store valid bits clear at once, no clearing pass.
// The output register lets the last column of a dump wait while the next word is accepted.
module time_bin_averager_core #(
    parameter int MAX_COLUMNS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tba_pkg::ADDR_W-1:0]    paddr,
    input  logic [tba_pkg::DATA_W-1:0]    pwdata,
    output logic [tba_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  tba_pkg::t_in_word             i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output tba_pkg::t_out_word            o_out_word
);

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int NW = $clog2(MAX_COLUMNS + 1);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_ACC     = 9'b000000010,
        S_BIN     = 9'b000000100,
        S_BIN_END = 9'b000001000,
        S_CENTRE  = 9'b000010000,
        S_RD      = 9'b000100000,
        S_AVG     = 9'b001000000,
        S_FIN     = 9'b010000000,
        S_PUT     = 9'b100000000
    } t_state;

    t_state                r_state, n_state;
    logic [4:0]            r_num_cols;
    logic [30:0]           r_period;
    logic [31:0]           r_fill;
    logic [NW-1:0]         r_pos, n_pos;
    logic [31:0]           r_cur_bin, n_cur_bin;
    logic [31:0]           r_rec_cnt, n_rec_cnt;
    logic                  r_acc_en, n_acc_en;
    logic [MAX_COLUMNS-1:0] r_vld, n_vld;
    logic                  r_flush, n_flush;
    logic [NW-1:0]         r_k, n_k;
    logic [6:0]            r_cnt, n_cnt;
    logic                  r_out_valid, n_out_valid;

    logic [31:0]           r_new_bin, n_new_bin;
    logic [31:0]           r_sample, n_sample;
    logic [31:0]           r_rem, n_rem;
    logic [63:0]           r_quo, n_quo;
    logic [63:0]           r_acc, n_acc;
    logic [63:0]           r_mcand, n_mcand;
    logic [31:0]           r_dvs, n_dvs;
    logic                  r_neg, n_neg;
    logic [31:0]           r_res, n_res;
    tba_pkg::t_out_word    r_out_word, n_out_word;

    tba_pkg::t_col_entry   r_mem [MAX_COLUMNS];
    tba_pkg::t_col_entry   r_mem_q;
    logic                  r_rd_vld;

    logic                  rd_en;
    logic [CW-1:0]         rd_addr;
    logic                  mem_we;
    logic [CW-1:0]         mem_waddr;
    tba_pkg::t_col_entry   mem_wdata;

    logic [30:0]           p_eff;
    logic [31:0]           nc32;
    logic [31:0]           n_eff32;
    logic [NW-1:0]         n_eff;
    logic [NW-1:0]         pos_eff;
    logic [NW-1:0]         pos_inc;
    logic [NW-1:0]         pos_next;
    logic [NW-1:0]         k_inc;
    logic                  k_last;
    logic                  in_take;
    logic                  out_free;
    logic                  cfg_wr;
    logic [31:0]           in_s;
    logic [31:0]           s_mag;

    logic [63:0]           add_a;
    logic [63:0]           add_b;
    logic                  add_ci;
    logic [64:0]           add_sum;
    logic [32:0]           rem_sh;

    logic [31:0]           bin_val;
    logic [63:0]           ent_sum;
    logic [31:0]           ent_cnt;
    logic [63:0]           smp_ext;
    logic                  sum_ovf;
    logic [63:0]           sat_sum;
    logic [63:0]           sum_mag;
    logic [31:0]           fin_val;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        unique case (paddr[3:2])
            tba_pkg::REG_NUM_COLUMNS: prdata = {27'd0, r_num_cols};
            tba_pkg::REG_BIN_PERIOD:  prdata = {1'b0, r_period};
            tba_pkg::REG_FILL_VALUE:  prdata = r_fill;
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= tba_pkg::NUM_COLUMNS_RST;
            r_period   <= tba_pkg::BIN_PERIOD_RST;
            r_fill     <= tba_pkg::FILL_VALUE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                tba_pkg::REG_NUM_COLUMNS: r_num_cols <= pwdata[4:0];
                tba_pkg::REG_BIN_PERIOD:  r_period   <= pwdata[30:0];
                tba_pkg::REG_FILL_VALUE:  r_fill     <= pwdata;
                default: ;
            endcase
        end
    end

    // Effective settings and record position
    assign p_eff   = (r_period == 31'd0) ? 31'd1 : r_period;
    assign nc32    = 32'(r_num_cols);
    assign n_eff32 = (nc32 < 32'd2) ? 32'd2 :
                     (nc32 > 32'(MAX_COLUMNS)) ? 32'(MAX_COLUMNS) : nc32;
    assign n_eff   = n_eff32[NW-1:0];
    assign pos_eff = (r_pos >= n_eff) ? '0 : r_pos;
    assign pos_inc = pos_eff + NW'(1);
    assign pos_next = (pos_inc >= n_eff) ? '0 : pos_inc;
    assign k_inc   = r_k + NW'(1);
    assign k_last  = (k_inc == n_eff);

    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid & ~o_in_stall;
    assign out_free   = ~r_out_valid | ~i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign in_s  = i_in_word.sample;
    assign s_mag = in_s[31] ? (32'd0 - in_s) : in_s;

    // Shared adder: divide step, multiply step or sum update
    assign rem_sh = {r_rem, r_quo[63]};

    always_comb begin
        unique case (r_state)
            S_ACC: begin
                add_a  = ent_sum;
                add_b  = smp_ext;
                add_ci = 1'b0;
            end
            S_CENTRE: begin
                add_a  = r_acc;
                add_b  = r_mcand;
                add_ci = 1'b0;
            end
            default: begin
                add_a  = {31'd0, rem_sh};
                add_b  = ~{32'd0, r_dvs};
                add_ci = 1'b1;
            end
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + 65'(add_ci);

    assign ent_sum = r_rd_vld ? r_mem_q.sum : 64'd0;
    assign ent_cnt = r_rd_vld ? r_mem_q.cnt : 32'd0;
    assign smp_ext = {{32{r_sample[31]}}, r_sample};
    assign sum_ovf = (add_a[63] == add_b[63]) && (add_sum[63] != add_a[63]);
    assign sat_sum = sum_ovf ? (add_b[63] ? tba_pkg::INT64_MIN : tba_pkg::INT64_MAX)
                             : add_sum[63:0];
    assign sum_mag = r_mem_q.sum[63] ? (64'd0 - r_mem_q.sum) : r_mem_q.sum;
    assign bin_val = r_neg ? (32'd0 - r_quo[31:0]) : r_quo[31:0];

    always_comb begin
        if (r_k == '0) begin
            fin_val = (r_acc > {32'd0, tba_pkg::INT32_MAX}) ? tba_pkg::INT32_MAX
                                                            : r_acc[31:0];
        end else if (r_neg) begin
            fin_val = (r_quo > {32'd0, tba_pkg::INT32_MIN}) ? tba_pkg::INT32_MIN
                                                            : (32'd0 - r_quo[31:0]);
        end else begin
            fin_val = (r_quo > {32'd0, tba_pkg::INT32_MAX}) ? tba_pkg::INT32_MAX
                                                            : r_quo[31:0];
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_cur_bin   = r_cur_bin;
        n_rec_cnt   = r_rec_cnt;
        n_acc_en    = r_acc_en;
        n_vld       = r_vld;
        n_flush     = r_flush;
        n_k         = r_k;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid & i_out_stall;
        n_new_bin   = r_new_bin;
        n_sample    = r_sample;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_acc       = r_acc;
        n_mcand     = r_mcand;
        n_dvs       = r_dvs;
        n_neg       = r_neg;
        n_res       = r_res;
        n_out_word  = r_out_word;
        rd_en       = 1'b0;
        rd_addr     = '0;
        mem_we      = 1'b0;
        mem_waddr   = r_k[CW-1:0];
        mem_wdata   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    if (i_in_word.kind) begin
                        if (r_rec_cnt != 32'd0) begin
                            n_flush = 1'b1;
                            n_k     = '0;
                            n_acc   = {34'd0, p_eff[30:1]};
                            n_mcand = {32'd0, r_cur_bin};
                            n_quo   = {33'd0, p_eff};
                            n_cnt   = 7'd31;
                            n_state = S_CENTRE;
                        end else begin
                            n_vld     = '0;
                            n_rec_cnt = '0;
                            n_pos     = '0;
                            n_cur_bin = tba_pkg::BIN_NONE;
                            n_acc_en  = 1'b0;
                        end
                    end else begin
                        n_pos = pos_next;
                        if (pos_eff == '0) begin
                            n_neg   = in_s[31];
                            n_quo   = {s_mag, 32'd0};
                            n_rem   = '0;
                            n_dvs   = {1'b0, p_eff};
                            n_cnt   = 7'd32;
                            n_state = S_BIN;
                        end else if (r_acc_en && (i_in_word.sample != r_fill)) begin
                            rd_en    = 1'b1;
                            rd_addr  = pos_eff[CW-1:0];
                            n_k      = pos_eff;
                            n_sample = in_s;
                            n_state  = S_ACC;
                        end
                    end
                end
            end

            S_ACC: begin
                mem_we        = 1'b1;
                mem_wdata.sum = sat_sum;
                mem_wdata.cnt = (ent_cnt == tba_pkg::UINT32_MAX) ? ent_cnt : ent_cnt + 32'd1;
                n_vld[r_k[CW-1:0]] = 1'b1;
                n_state       = S_IDLE;
            end

            S_BIN, S_AVG: begin
                if (add_sum[64]) begin
                    n_rem = add_sum[31:0];
                end else begin
                    n_rem = rem_sh[31:0];
                end
                n_quo = {r_quo[62:0], add_sum[64]};
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_state = (r_state == S_BIN) ? S_BIN_END : S_FIN;
                end
            end

            S_BIN_END: begin
                n_new_bin = bin_val;
                if (bin_val != r_cur_bin) begin
                    if (r_rec_cnt != 32'd0) begin
                        n_flush = 1'b0;
                        n_k     = '0;
                        n_acc   = {34'd0, p_eff[30:1]};
                        n_mcand = {32'd0, r_cur_bin};
                        n_quo   = {33'd0, p_eff};
                        n_cnt   = 7'd31;
                        n_state = S_CENTRE;
                    end else begin
                        n_vld     = '0;
                        n_cur_bin = bin_val;
                        n_acc_en  = ~bin_val[31];
                        n_rec_cnt = bin_val[31] ? 32'd0 : 32'd1;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_acc_en = ~bin_val[31];
                    if (!bin_val[31] && (r_rec_cnt != tba_pkg::UINT32_MAX)) begin
                        n_rec_cnt = r_rec_cnt + 32'd1;
                    end
                    n_state = S_IDLE;
                end
            end

            S_CENTRE: begin
                if (r_quo[0]) begin
                    n_acc = add_sum[63:0];
                end
                n_mcand = {r_mcand[62:0], 1'b0};
                n_quo   = {1'b0, r_quo[63:1]};
                n_cnt   = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_state = S_FIN;
                end
            end

            S_RD: begin
                if (!r_rd_vld || (r_mem_q.cnt == 32'd0)) begin
                    n_res   = '0;
                    n_state = S_PUT;
                end else begin
                    n_neg   = r_mem_q.sum[63];
                    n_quo   = sum_mag;
                    n_rem   = '0;
                    n_dvs   = r_mem_q.cnt;
                    n_cnt   = 7'd64;
                    n_state = S_AVG;
                end
            end

            S_FIN: begin
                n_res   = fin_val;
                n_state = S_PUT;
            end

            S_PUT: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out_word.out_column = 4'(r_k);
                    n_out_word.out_value  = r_res;
                    n_out_word.last       = k_last;
                    if (k_last) begin
                        n_vld = '0;
                        if (r_flush) begin
                            n_rec_cnt = '0;
                            n_pos     = '0;
                            n_cur_bin = tba_pkg::BIN_NONE;
                            n_acc_en  = 1'b0;
                        end else begin
                            n_cur_bin = r_new_bin;
                            n_acc_en  = ~r_new_bin[31];
                            n_rec_cnt = r_new_bin[31] ? 32'd0 : 32'd1;
                        end
                        n_state = S_IDLE;
                    end else begin
                        n_k     = k_inc;
                        rd_en   = 1'b1;
                        rd_addr = k_inc[CW-1:0];
                        n_state = S_RD;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_cur_bin   <= tba_pkg::BIN_NONE;
            r_rec_cnt   <= '0;
            r_acc_en    <= 1'b0;
            r_vld       <= '0;
            r_flush     <= 1'b0;
            r_k         <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_cur_bin   <= n_cur_bin;
            r_rec_cnt   <= n_rec_cnt;
            r_acc_en    <= n_acc_en;
            r_vld       <= n_vld;
            r_flush     <= n_flush;
            r_k         <= n_k;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new_bin  <= n_new_bin;
        r_sample   <= n_sample;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_acc      <= n_acc;
        r_mcand    <= n_mcand;
        r_dvs      <= n_dvs;
        r_neg      <= n_neg;
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    // Column store: sum and count per column
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_mem_q  <= r_mem[rd_addr];
            r_rd_vld <= r_vld[rd_addr];
        end
    end

endmodule

FILE: sv/tba_checker.sv
`include "assert_macros.svh"

module tba_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input tba_pkg::t_out_word o_out_word
);

    `TBA_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid, "output word dropped while stalled")
    `TBA_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall |=> $stable(o_out_word), "output word changed while stalled")
    `TBA_ASSERT(a_busy_mid_dump, i_clk, i_rst_n, o_out_valid && !o_out_word.last |-> o_in_stall, "input taken in the middle of a bin dump")
    `TBA_ASSERT_ALL(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "block not idle after reset")

endmodule

bind time_bin_averager_core tba_checker u_tba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
